// ===== design/tlf_pkg.sv =====
// ============================================================================
// tlf_pkg: shared types and constants for the two-point r-z line fit
// Field widths, fixed-point constants and the word passed from front to back.
// ============================================================================
package tlf_pkg;

    // Position fields, radius and difference widths.
    localparam int POS_W  = 20;
    localparam int RAD_W  = 20;
    localparam int SQ_W   = 2 * POS_W;
    localparam int DIF_W  = POS_W + 1;
    localparam int FRAC_W = 16;
    localparam int NUM_W  = DIF_W + FRAC_W;
    localparam int OUT_W  = 32;

    // Default depth of the queue between front and back.
    localparam int FIFO_DEPTH_DEF = 4;

    // Result constants.
    localparam logic signed [OUT_W-1:0] SAT_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [OUT_W-1:0] SAT_MIN     = 32'sh8000_0000;
    localparam logic signed [OUT_W-1:0] NOPOS_SLOPE = -32'sd65536;
    localparam logic signed [OUT_W-1:0] NOPOS_ICPT  = -32'sd1024;

    // Word handed from the front to the back through the queue.
    typedef struct packed {
        logic [RAD_W-1:0]        r0;
        logic signed [DIF_W-1:0] dr;
        logic signed [DIF_W-1:0] dz;
        logic signed [POS_W-1:0] z0;
        logic                    has_pos;
    } t_fit_entry;

endpackage

// ===== design/tlf_if.sv =====
// ============================================================================
// tlf_if: valid/ready channels of the line fit
// Input channel with the two hits and output channel with the fit result.
// ============================================================================
interface tlf_in_if;
    import tlf_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] x_first;
    logic signed [POS_W-1:0] y_first;
    logic signed [POS_W-1:0] z_first;
    logic signed [POS_W-1:0] x_second;
    logic signed [POS_W-1:0] y_second;
    logic signed [POS_W-1:0] z_second;
    logic                    has_positions;

    modport source (output valid, x_first, y_first, z_first, x_second, y_second,
                    z_second, has_positions, input ready);
    modport sink   (input valid, x_first, y_first, z_first, x_second, y_second,
                    z_second, has_positions, output ready);
endinterface

interface tlf_out_if;
    import tlf_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] slope;
    logic signed [OUT_W-1:0] intercept;
    logic                    result_valid;
    logic                    divide_fault;

    modport source (output valid, slope, intercept, result_valid, divide_fault,
                    input ready);
    modport sink   (input valid, slope, intercept, result_valid, divide_fault,
                    output ready);
endinterface

// ===== design/tlf_front.sv =====
// ============================================================================
// tlf_front: input stage, squares and pipelined square roots
// Takes a word, forms both radii one root bit per stage and the differences.
// ============================================================================
module tlf_front import tlf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tlf_in_if.sink     i_in,
    input  logic       i_full,
    output logic       o_push,
    output t_fit_entry o_entry
);

    // Input register.
    logic                    r_v_in;
    logic signed [POS_W-1:0] r_x0, r_y0, r_z0, r_x1, r_y1, r_z1;
    logic                    r_hp_in;

    // Root pipeline: entry 0 holds the squares, entry RAD_W the finished roots.
    logic             r_sv  [0:RAD_W];
    logic [SQ_W-1:0]  r_rem0[0:RAD_W];
    logic [SQ_W-1:0]  r_rem1[0:RAD_W];
    logic [RAD_W-1:0] r_q0  [0:RAD_W];
    logic [RAD_W-1:0] r_q1  [0:RAD_W];
    logic [POS_W-1:0] r_zf  [0:RAD_W];
    logic [POS_W-1:0] r_zs  [0:RAD_W];
    logic             r_hp  [0:RAD_W];

    // Output register toward the queue.
    logic       r_v_out;
    t_fit_entry r_entry;

    logic adv;
    logic signed [SQ_W-1:0] xx0, yy0, xx1, yy1;

    // The whole front moves when its last stage is empty or being pushed.
    assign adv      = !r_v_out || !i_full;
    assign i_in.ready = adv;
    assign o_push   = r_v_out && !i_full;
    assign o_entry  = r_entry;

    // Capture an accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in <= 1'b0;
        end else if (adv) begin
            r_v_in <= i_in.valid;
        end
        if (adv) begin
            r_x0    <= i_in.x_first;
            r_y0    <= i_in.y_first;
            r_z0    <= i_in.z_first;
            r_x1    <= i_in.x_second;
            r_y1    <= i_in.y_second;
            r_z1    <= i_in.z_second;
            r_hp_in <= i_in.has_positions;
        end
    end

    // Squared radii.
    assign xx0 = r_x0 * r_x0;
    assign yy0 = r_y0 * r_y0;
    assign xx1 = r_x1 * r_x1;
    assign yy1 = r_y1 * r_y1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (adv) begin
            r_sv[0] <= r_v_in;
        end
        if (adv) begin
            r_rem0[0] <= xx0 + yy0;
            r_rem1[0] <= xx1 + yy1;
            r_q0[0]   <= '0;
            r_q1[0]   <= '0;
            r_zf[0]   <= r_z0;
            r_zs[0]   <= r_z1;
            r_hp[0]   <= r_hp_in;
        end
    end

    // One root bit per stage, most significant bit first.
    for (genvar j = 0; j < RAD_W; j++) begin : g_root
        localparam int K = RAD_W - 1 - j;
        logic [SQ_W:0] t0, t1;
        logic          ge0, ge1;

        assign t0  = ((SQ_W+1)'(r_q0[j]) << (K + 1)) | ((SQ_W+1)'(1) << (2 * K));
        assign t1  = ((SQ_W+1)'(r_q1[j]) << (K + 1)) | ((SQ_W+1)'(1) << (2 * K));
        assign ge0 = {1'b0, r_rem0[j]} >= t0;
        assign ge1 = {1'b0, r_rem1[j]} >= t1;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j+1] <= 1'b0;
            end else if (adv) begin
                r_sv[j+1] <= r_sv[j];
            end
            if (adv) begin
                r_rem0[j+1] <= ge0 ? r_rem0[j] - t0[SQ_W-1:0] : r_rem0[j];
                r_rem1[j+1] <= ge1 ? r_rem1[j] - t1[SQ_W-1:0] : r_rem1[j];
                r_q0[j+1]   <= ge0 ? (r_q0[j] | (RAD_W'(1) << K)) : r_q0[j];
                r_q1[j+1]   <= ge1 ? (r_q1[j] | (RAD_W'(1) << K)) : r_q1[j];
                r_zf[j+1]   <= r_zf[j];
                r_zs[j+1]   <= r_zs[j];
                r_hp[j+1]   <= r_hp[j];
            end
        end
    end

    // Radius and z differences for the back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_out <= 1'b0;
        end else if (adv) begin
            r_v_out <= r_sv[RAD_W];
        end
        if (adv) begin
            r_entry.r0      <= r_q0[RAD_W];
            r_entry.dr      <= $signed(DIF_W'(r_q1[RAD_W]) - DIF_W'(r_q0[RAD_W]));
            r_entry.dz      <= DIF_W'($signed(r_zs[RAD_W])) - DIF_W'($signed(r_zf[RAD_W]));
            r_entry.z0      <= $signed(r_zf[RAD_W]);
            r_entry.has_pos <= r_hp[RAD_W];
        end
    end

endmodule

// ===== design/tlf_fifo.sv =====
// ============================================================================
// tlf_fifo: short queue between front and back
// Holds words from the front so that each side can stall on its own.
// ============================================================================
module tlf_fifo import tlf_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_fit_entry i_entry,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_valid,
    output t_fit_entry o_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_fit_entry       r_mem [0:DEPTH-1];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_entry = r_mem[r_rd];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // The count stays within the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    // A lone push raises the count by one.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not follow a push");

    // The back only pops a word that is there.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

endmodule

// ===== design/tlf_back.sv =====
// ============================================================================
// tlf_back: slope division, intercept product and result register
// Restoring division one quotient bit per stage, then product and rounding.
// ============================================================================
module tlf_back import tlf_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_fit_entry              i_entry,
    output logic                    o_pop,
    input  logic signed [POS_W-1:0] i_z_offset,
    tlf_out_if.source               o_out
);

    localparam int DIV_N  = NUM_W;
    localparam int PROD_W = OUT_W + DIF_W;
    localparam int QQ_W   = PROD_W - FRAC_W;
    localparam int ICPT_W = QQ_W + 3;

    typedef struct packed {
        logic [DIF_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [DIF_W-1:0] ud;
    } t_div;

    typedef struct packed {
        logic                    neg;
        logic                    dr_pos;
        logic                    dr_neg;
        logic                    fault;
        logic                    has_pos;
        logic [RAD_W-1:0]        r0;
        logic signed [POS_W-1:0] z0;
    } t_side;

    logic  r_dv [0:DIV_N];
    t_div  r_div[0:DIV_N];
    t_side r_sd [0:DIV_N];

    logic                     r_v_s, r_v_m, r_v_a, r_ov;
    t_side                    r_sd_s, r_sd_m, r_sd_a;
    logic signed [OUT_W-1:0]  r_slope_s, r_slope_m, r_slope_a;
    logic signed [DIF_W-1:0]  r_dzo;
    logic signed [PROD_W-1:0] r_prod;
    logic [QQ_W-1:0]          r_qq;
    logic                     r_psign;
    logic signed [OUT_W-1:0]  r_o_slope, r_o_icpt;
    logic                     r_o_rv, r_o_fault;

    logic                    adv;
    logic [DIF_W-1:0]        ud, adr;
    logic [NUM_W-1:0]        q;
    logic signed [OUT_W-1:0] n_slope;
    logic [PROD_W-1:0]       mag;
    logic [PROD_W-1:0]       rnd;
    logic signed [ICPT_W-1:0] icpt;
    logic signed [OUT_W-1:0] n_icpt;

    // The back moves whenever the result register is free or being taken.
    assign adv   = !r_ov || o_out.ready;
    assign o_pop = adv && i_valid;

    // Magnitudes and rounded dividend.
    assign ud  = i_entry.dz[DIF_W-1] ? DIF_W'(-i_entry.dz) : DIF_W'(i_entry.dz);
    assign adr = i_entry.dr[DIF_W-1] ? DIF_W'(-i_entry.dr) : DIF_W'(i_entry.dr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (adv) begin
            r_dv[0] <= i_valid;
        end
        if (adv) begin
            r_div[0].rem    <= '0;
            r_div[0].num    <= {adr, FRAC_W'(0)} + NUM_W'(ud >> 1);
            r_div[0].ud     <= ud;
            r_sd[0].neg     <= i_entry.dr[DIF_W-1] ^ i_entry.dz[DIF_W-1];
            r_sd[0].dr_pos  <= !i_entry.dr[DIF_W-1] && (i_entry.dr != '0);
            r_sd[0].dr_neg  <= i_entry.dr[DIF_W-1];
            r_sd[0].fault   <= i_entry.dz == '0;
            r_sd[0].has_pos <= i_entry.has_pos;
            r_sd[0].r0      <= i_entry.r0;
            r_sd[0].z0      <= i_entry.z0;
        end
    end

    // One quotient bit per stage; quotient bits shift into the dividend.
    for (genvar j = 0; j < DIV_N; j++) begin : g_div
        logic [DIF_W:0] sh;
        logic           ge;

        assign sh = {r_div[j].rem, r_div[j].num[NUM_W-1]};
        assign ge = sh >= {1'b0, r_div[j].ud};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1] <= 1'b0;
            end else if (adv) begin
                r_dv[j+1] <= r_dv[j];
            end
            if (adv) begin
                r_div[j+1].rem <= ge ? DIF_W'(sh - {1'b0, r_div[j].ud}) : DIF_W'(sh);
                r_div[j+1].num <= {r_div[j].num[NUM_W-2:0], ge};
                r_div[j+1].ud  <= r_div[j].ud;
                r_sd[j+1]      <= r_sd[j];
            end
        end
    end

    // Signed, saturated slope.
    assign q = r_div[DIV_N].num;

    always_comb begin
        if (r_sd[DIV_N].fault) begin
            n_slope = r_sd[DIV_N].dr_pos ? SAT_MAX :
                      (r_sd[DIV_N].dr_neg ? SAT_MIN : '0);
        end else if (!r_sd[DIV_N].neg) begin
            n_slope = (|q[NUM_W-1:OUT_W-1]) ? SAT_MAX : $signed(q[OUT_W-1:0]);
        end else begin
            n_slope = (|q[NUM_W-1:OUT_W-1]) ? SAT_MIN : $signed(-q[OUT_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_s <= 1'b0;
            r_v_m <= 1'b0;
            r_v_a <= 1'b0;
        end else if (adv) begin
            r_v_s <= r_dv[DIV_N];
            r_v_m <= r_v_s;
            r_v_a <= r_v_m;
        end
        if (adv) begin
            r_slope_s <= n_slope;
            r_sd_s    <= r_sd[DIV_N];
            r_dzo     <= DIF_W'(r_sd[DIV_N].z0) - DIF_W'(i_z_offset);
            // Exact product of slope and distance to the reference plane.
            r_prod    <= PROD_W'(r_slope_s) * PROD_W'(r_dzo);
            r_slope_m <= r_slope_s;
            r_sd_m    <= r_sd_s;
            // Magnitude divided by 2^16, rounded half away from zero.
            r_qq      <= rnd[PROD_W-1:FRAC_W];
            r_psign   <= r_prod[PROD_W-1];
            r_slope_a <= r_slope_m;
            r_sd_a    <= r_sd_m;
        end
    end

    assign mag = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
    assign rnd = mag + (PROD_W'(1) << (FRAC_W - 1));

    // Intercept and saturation.
    assign icpt = r_psign ? $signed(ICPT_W'(r_sd_a.r0) + ICPT_W'(r_qq))
                          : $signed(ICPT_W'(r_sd_a.r0) - ICPT_W'(r_qq));

    always_comb begin
        if (icpt > ICPT_W'(SAT_MAX)) begin
            n_icpt = SAT_MAX;
        end else if (icpt < ICPT_W'(SAT_MIN)) begin
            n_icpt = SAT_MIN;
        end else begin
            n_icpt = icpt[OUT_W-1:0];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_v_a;
        end
        if (adv) begin
            r_o_slope <= r_sd_a.has_pos ? r_slope_a : NOPOS_SLOPE;
            r_o_icpt  <= r_sd_a.has_pos ? n_icpt : NOPOS_ICPT;
            r_o_rv    <= r_sd_a.has_pos;
            r_o_fault <= r_sd_a.has_pos && r_sd_a.fault;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.slope        = r_o_slope;
    assign o_out.intercept    = r_o_icpt;
    assign o_out.result_valid = r_o_rv;
    assign o_out.divide_fault = r_o_fault;

    // A fault is only reported on a computed result.
    a_fault_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_fault) |-> r_o_rv)
        else $error("fault flagged on a result without positions");

endmodule

// ===== design/two_point_rz_line_fit.sv =====
// Throughput: one word per cycle while nothing stalls; 20 root stages and 37 quotient stages are pipelined.
// The front and back are parted by a queue of FIFO_DEPTH words and stall separately.
// Reset: synchronous, active low; clears all valid flags, the queue and z_offset.
// ============================================================================
// two_point_rz_line_fit: top level of the two-point r-z line fit
// Holds the z_offset register and joins front, queue and back.
// ============================================================================
module two_point_rz_line_fit import tlf_pkg::*; #(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tlf_in_if.sink           i_in,
    tlf_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic [POS_W-1:0] i_cfg_wdata
);

    logic signed [POS_W-1:0] r_z_offset;
    logic       push, full, pop, q_valid;
    t_fit_entry f_entry, b_entry;

    // Reference plane register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_offset <= '0;
        end else if (i_cfg_we) begin
            r_z_offset <= $signed(i_cfg_wdata);
        end
    end

    tlf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_entry (f_entry)
    );

    tlf_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (b_entry)
    );

    tlf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_entry    (b_entry),
        .o_pop      (pop),
        .i_z_offset (r_z_offset),
        .o_out      (o_out)
    );

endmodule
